FILE: hw/rtl/hsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_pkg: shared types and constants of the heartbeat sentence parser
// character codes, framing states, status record and the tag lookup
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int unsigned TIMEOUT_W    = 16;
  localparam int unsigned FREE_W       = 20;
  localparam int unsigned RATE_W       = 8;
  localparam int unsigned SIL_W        = 17;
  localparam int unsigned MAX_LINE_DEF = 128;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd3000;
  localparam logic [FREE_W-1:0]    FREE_MAX    = 20'hFFFFF;
  localparam logic [SIL_W-1:0]     SIL_MAX     = 17'h1FFFF;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;

  localparam logic [2:0] TAG_LEN = 3'd5;
  localparam logic [2:0] TAG_BAD = 3'd6;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_BODY  = 4'b0010,
    PH_CHECK = 4'b0100,
    PH_SKIP  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    PS_RUN  = 3'b001,
    PS_FAIL = 3'b010,
    PS_DONE = 3'b100
  } pstat_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_HEARTBEAT = 2'd1,
    EV_CRC_ERR   = 2'd2,
    EV_LINK_LOST = 2'd3
  } event_t;

  // end-of-line summary from the parser to the link monitor
  typedef struct packed {
    logic              line_done;
    logic              crc_ok;
    logic              hb_ok;
    logic              rec;
    logic [FREE_W-1:0] free;
    logic [RATE_W-1:0] rate;
  } line_end_t;

  typedef struct packed {
    logic              connected;
    logic              recording;
    logic [FREE_W-1:0] free;
    logic [RATE_W-1:0] rate;
    event_t            ev;
  } status_t;

  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h50; // P
      3'd1:    c = 8'h34; // 4
      3'd2:    c = 8'h48; // H
      3'd3:    c = 8'h42; // B
      3'd4:    c = CH_COMMA;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // {is_hex, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/heartbeat_sentence_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_sentence_parser_top: checksummed heartbeat sentence receiver
// input register, per-byte parse and link logic, result register
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_      | in        | in_valid / in_ready  | in_command, in_rx_byte
//  out_     | out       | out_valid / out_ready| out_connected, out_recording,
//           |           |                      | out_free_centi_gb, out_frame_rate,
//           |           |                      | out_event_res
//  cfg_     | in        | cfg_wr_en            | cfg_wr_data (timeout_ms)
//
// one transaction per cycle sustained while out_ready holds; an accepted input
// passes the input register, then the result register, to become a result
// the per-byte parse step lies between the two registers
// rst_n is synchronous; it resets all line, link and handshake state
// a stalled result holds in the result register while one more input waits
// in the input register; input ready drops only when both are full
// ----------------------------------------------------------------------------
module heartbeat_sentence_parser_top #(
  parameter int unsigned MAX_LINE = hsp_pkg::MAX_LINE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [hsp_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_connected,
  output logic                          out_recording,
  output logic [hsp_pkg::FREE_W-1:0]    out_free_centi_gb,
  output logic [hsp_pkg::RATE_W-1:0]    out_frame_rate,
  output logic [1:0]                    out_event_res
);
  import hsp_pkg::*;

  logic       in_vld_r;
  logic       cmd_r;
  logic [7:0] byte_r;
  logic       out_vld_r;
  status_t    res_r;
  status_t    status_nxt;
  line_end_t  line_end;
  logic       adv;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  hsp_line_parser #(
    .MAX_LINE (MAX_LINE)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .cmd      (cmd_r),
    .rx_byte  (byte_r),
    .line_end (line_end)
  );

  hsp_link_monitor u_link (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .adv         (adv),
    .cmd         (cmd_r),
    .line_end    (line_end),
    .status_nxt  (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_command;
      byte_r <= in_rx_byte;
    end
    if (adv) begin
      res_r <= status_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_connected     = res_r.connected;
  assign out_recording     = res_r.recording;
  assign out_free_centi_gb = res_r.free;
  assign out_frame_rate    = res_r.rate;
  assign out_event_res     = res_r.ev;

endmodule

FILE: hw/rtl/hsp_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_line_parser: sentence framing, checksum and field parsing
// tracks one line per byte, reports a summary at the newline
// ----------------------------------------------------------------------------
module hsp_line_parser #(
  parameter int unsigned MAX_LINE = hsp_pkg::MAX_LINE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                cmd,
  input  logic [7:0]          rx_byte,
  output hsp_pkg::line_end_t  line_end
);
  import hsp_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_LINE + 1);
  localparam logic [LEN_W-1:0] LEN_LIM = LEN_W'(MAX_LINE);

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [7:0]        chk_r, chk_nxt;
  logic [2:0]        tag_r, tag_nxt;
  logic [1:0]        fld_r, fld_nxt;
  logic              rec_r, rec_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [1:0]        frac_r, frac_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [2:0]        seen_r, seen_nxt;
  logic              point_r, point_nxt;
  pstat_t            pst_r, pst_nxt;
  logic              hstop_r, hstop_nxt;

  logic              is_dig;
  logic [3:0]        dig;
  logic [4:0]        hexv;
  logic [FREE_W+4:0] free_int;
  logic [FREE_W:0]   free_frac;
  logic [RATE_W+3:0] rate_mul;

  assign is_dig = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign dig    = is_dig ? rx_byte[3:0] : 4'd0;
  assign hexv   = hex_value(rx_byte);

  // free*10 + d*100 and the fraction step, both saturated below
  assign free_int  = {2'b0, free_r, 3'b0} + {4'b0, free_r, 1'b0}
                   + (FREE_W+5)'({dig, 6'b0}) + (FREE_W+5)'({dig, 5'b0})
                   + (FREE_W+5)'({dig, 2'b0});
  assign free_frac = {1'b0, free_r}
                   + ((frac_r == 2'd0) ? (FREE_W+1)'({dig, 3'b0} + {dig, 1'b0})
                                       : (FREE_W+1)'(dig));
  assign rate_mul  = {1'b0, rate_r, 3'b0} + {3'b0, rate_r, 1'b0} + (RATE_W+4)'(dig);

  assign line_end.line_done = adv && !cmd && (rx_byte == CH_LF) && (phase_r == PH_CHECK);
  assign line_end.crc_ok    = (chk_r == xor_r);
  assign line_end.hb_ok     = (tag_r == TAG_LEN) && (pst_r != PS_FAIL)
                           && (fld_r == 2'd2) && seen_r[2];
  assign line_end.rec       = rec_r;
  assign line_end.free      = free_r;
  assign line_end.rate      = rate_r;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    chk_nxt   = chk_r;
    tag_nxt   = tag_r;
    fld_nxt   = fld_r;
    rec_nxt   = rec_r;
    free_nxt  = free_r;
    frac_nxt  = frac_r;
    rate_nxt  = rate_r;
    seen_nxt  = seen_r;
    point_nxt = point_r;
    pst_nxt   = pst_r;
    hstop_nxt = hstop_r;
    if (adv && !cmd && rx_byte != CH_CR) begin
      if (rx_byte == CH_LF) begin
        phase_nxt = PH_START;
        len_nxt   = '0;
        xor_nxt   = '0;
        chk_nxt   = '0;
        tag_nxt   = '0;
        fld_nxt   = '0;
        rec_nxt   = 1'b0;
        free_nxt  = '0;
        frac_nxt  = '0;
        rate_nxt  = '0;
        seen_nxt  = '0;
        point_nxt = 1'b0;
        pst_nxt   = PS_RUN;
        hstop_nxt = 1'b0;
      end else if (phase_r != PH_SKIP) begin
        len_nxt = len_r + 1'b1;
        if (len_nxt >= LEN_LIM) begin
          phase_nxt = PH_SKIP;
        end else begin
          unique case (phase_r)
            PH_START: begin
              phase_nxt = (rx_byte == CH_DOLLAR) ? PH_BODY : PH_SKIP;
            end
            PH_BODY: begin
              if (rx_byte == CH_STAR) begin
                phase_nxt = PH_CHECK;
              end else begin
                xor_nxt = xor_r ^ rx_byte;
                if (tag_r < TAG_LEN) begin
                  tag_nxt = (rx_byte == tag_char(tag_r)) ? tag_r + 3'd1 : TAG_BAD;
                end else if (tag_r == TAG_LEN && pst_r == PS_RUN) begin
                  if (fld_r == 2'd0) begin
                    if (is_dig) begin
                      seen_nxt[0] = 1'b1;
                      if (dig != 4'd0) rec_nxt = 1'b1;
                    end else if (rx_byte == CH_COMMA && seen_r[0]) begin
                      fld_nxt = 2'd1;
                    end else begin
                      pst_nxt = PS_FAIL;
                    end
                  end else if (fld_r == 2'd1) begin
                    if (is_dig) begin
                      seen_nxt[1] = 1'b1;
                      if (!point_r) begin
                        free_nxt = (free_int > (FREE_W+5)'(FREE_MAX)) ? FREE_MAX
                                 : free_int[FREE_W-1:0];
                      end else if (frac_r < 2'd2) begin
                        free_nxt = free_frac[FREE_W] ? FREE_MAX : free_frac[FREE_W-1:0];
                        frac_nxt = frac_r + 2'd1;
                      end
                    end else if (rx_byte == CH_POINT && !point_r) begin
                      point_nxt = 1'b1;
                    end else if (rx_byte == CH_COMMA && seen_r[1]) begin
                      fld_nxt = 2'd2;
                    end else begin
                      pst_nxt = PS_FAIL;
                    end
                  end else begin
                    if (is_dig) begin
                      seen_nxt[2] = 1'b1;
                      rate_nxt    = rate_mul[RATE_W-1:0];
                    end else begin
                      pst_nxt = seen_r[2] ? PS_DONE : PS_FAIL;
                    end
                  end
                end
              end
            end
            PH_CHECK: begin
              if (!hstop_r) begin
                if (hexv[4]) chk_nxt = {chk_r[3:0], hexv[3:0]};
                else         hstop_nxt = 1'b1;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      len_r   <= '0;
      xor_r   <= '0;
      chk_r   <= '0;
      tag_r   <= '0;
      fld_r   <= '0;
      rec_r   <= 1'b0;
      free_r  <= '0;
      frac_r  <= '0;
      rate_r  <= '0;
      seen_r  <= '0;
      point_r <= 1'b0;
      pst_r   <= PS_RUN;
      hstop_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      chk_r   <= chk_nxt;
      tag_r   <= tag_nxt;
      fld_r   <= fld_nxt;
      rec_r   <= rec_nxt;
      free_r  <= free_nxt;
      frac_r  <= frac_nxt;
      rate_r  <= rate_nxt;
      seen_r  <= seen_nxt;
      point_r <= point_nxt;
      pst_r   <= pst_nxt;
      hstop_r <= hstop_nxt;
    end
  end

endmodule

FILE: hw/rtl/hsp_link_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_link_monitor: saved heartbeat status and silence timeout
// holds the timeout register, counts ticks and picks the event code
// ----------------------------------------------------------------------------
module hsp_link_monitor (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [hsp_pkg::TIMEOUT_W-1:0]         cfg_wr_data,
  input  logic                                  adv,
  input  logic                                  cmd,
  input  hsp_pkg::line_end_t                    line_end,
  output hsp_pkg::status_t                      status_nxt
);
  import hsp_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 conn_r, conn_nxt;
  logic                 rec_r, rec_nxt;
  logic [FREE_W-1:0]    free_r, free_nxt;
  logic [RATE_W-1:0]    rate_r, rate_nxt;
  logic [SIL_W-1:0]     sil_r, sil_nxt;
  event_t               ev;

  always_comb begin
    conn_nxt = conn_r;
    rec_nxt  = rec_r;
    free_nxt = free_r;
    rate_nxt = rate_r;
    sil_nxt  = sil_r;
    ev       = EV_NONE;
    if (adv && cmd) begin
      if (sil_r != SIL_MAX) sil_nxt = sil_r + 1'b1;
      if (conn_r && sil_nxt > SIL_W'(timeout_r)) begin
        conn_nxt = 1'b0;
        ev       = EV_LINK_LOST;
      end
    end else if (line_end.line_done) begin
      if (!line_end.crc_ok) begin
        ev = EV_CRC_ERR;
      end else if (line_end.hb_ok) begin
        conn_nxt = 1'b1;
        rec_nxt  = line_end.rec;
        free_nxt = line_end.free;
        rate_nxt = line_end.rate;
        sil_nxt  = '0;
        ev       = EV_HEARTBEAT;
      end
    end
  end

  assign status_nxt.connected = conn_nxt;
  assign status_nxt.recording = rec_nxt;
  assign status_nxt.free      = free_nxt;
  assign status_nxt.rate      = rate_nxt;
  assign status_nxt.ev        = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      conn_r    <= 1'b0;
      rec_r     <= 1'b0;
      free_r    <= '0;
      rate_r    <= '0;
      sil_r     <= '0;
    end else begin
      if (cfg_wr_en) timeout_r <= cfg_wr_data;
      conn_r <= conn_nxt;
      rec_r  <= rec_nxt;
      free_r <= free_nxt;
      rate_r <= rate_nxt;
      sil_r  <= sil_nxt;
    end
  end

endmodule

FILE: hw/rtl/hsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsp_checker: port-level checks of the heartbeat sentence parser
// watches the top level ports and is bound to every instance
// ----------------------------------------------------------------------------
module hsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_command,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_connected,
  input logic [1:0] out_event_res
);
  import hsp_pkg::*;

  // a stalled result transaction keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_no_out_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_hb_connects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_HEARTBEAT |-> out_connected)
    else $error("heartbeat event without link up");

  a_lost_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_LINK_LOST |-> !out_connected)
    else $error("link lost event with link still up");

  // a byte that is not a newline can raise no event; with both registers
  // empty its result passes the input register, then the result register
  a_no_event_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_command && in_rx_byte != CH_LF && !out_valid
    && !$past(in_valid && in_ready)
    |=> ##1 (!out_valid || out_event_res == EV_NONE))
    else $error("event raised by a byte that ends no line");

endmodule

bind heartbeat_sentence_parser_top hsp_checker u_hsp_checker (.*);
